// ----- rtl/core/wildcard_glob_matcher_top_assert.svh -----
// ----------------------------------------------------------------------------
// wildcard glob matcher assertion macros
// shared assertion forms, sampled on clock and disabled in reset
// ----------------------------------------------------------------------------
`ifndef WILDCARD_GLOB_MATCHER_TOP_ASSERT_SVH
`define WILDCARD_GLOB_MATCHER_TOP_ASSERT_SVH

// same-cycle implication
`define WGM_ASSERT_IMPLY(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("wildcard glob matcher: same-cycle check failed");

// next-cycle implication
`define WGM_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("wildcard glob matcher: next-cycle check failed");

`endif

// ----- rtl/core/wgm_pkg.sv -----
// ----------------------------------------------------------------------------
// wgm_pkg
// constants and types of the wildcard glob matcher
// ----------------------------------------------------------------------------
`default_nettype none

package wgm_pkg;

   localparam int MAX_PATTERN = 32;
   localparam int UNIT_W      = 16;
   localparam int CODE_W      = 16;
   localparam int NPOS        = MAX_PATTERN + 1;
   localparam int LEN_W       = $clog2(NPOS);
   localparam int IDX_W       = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
   localparam int LVLS        = $clog2(NPOS);

   localparam int REQ_DATA_W  = ((CODE_W + 7) / 8) * 8;
   localparam int RSP_DATA_W  = 8;

   localparam logic [UNIT_W-1:0] STAR_UNIT     = UNIT_W'(8'h2A);
   localparam logic [UNIT_W-1:0] QUESTION_UNIT = UNIT_W'(8'h3F);

   typedef enum logic [1:0] {
      ACT_CLEAR  = 2'd0,
      ACT_APPEND = 2'd1,
      ACT_TEXT   = 2'd2,
      ACT_END    = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      KIND_LITERAL  = 2'd0,
      KIND_STAR     = 2'd1,
      KIND_QUESTION = 2'd2
   } kind_type;

   typedef struct packed {
      kind_type            kind;
      logic [UNIT_W-1:0]   unit;
   } entry_type;

endpackage

`default_nettype wire

// ----- rtl/core/wildcard_glob_matcher_top.sv -----
// ----------------------------------------------------------------------------
// wildcard_glob_matcher_top
// whole-string '*' / '?' glob matcher with a bit-parallel nfa over positions
// ----------------------------------------------------------------------------
//  channel   direction  tdata                            tuser
//  req_      in         [15:0] code_unit                 [1:0] action
//  rsp_      out        [0] matched, [1] pattern_overflow, [7:2] zero   -
//
//  one item per cycle sustained while no pending result holds back an
//  end-of-text item; an item sits in the input register, and its state update
//  and any end-of-text result are registered when it leaves that register
//  every pattern position is updated at once by the nfa lanes plus a
//  log-depth star closure network
//  reset is synchronous; pattern store contents are not cleared
//  a pending result stalls only a following end-of-text item
// ----------------------------------------------------------------------------
`default_nettype none

module wildcard_glob_matcher_top (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_tvalid,
   output      logic                             req_tready,
   input  wire logic [wgm_pkg::REQ_DATA_W-1:0]   req_tdata,  // [15:0] code_unit
   input  wire logic [1:0]                       req_tuser,  // [1:0] action
   output      logic                             rsp_tvalid,
   input  wire logic                             rsp_tready,
   output      logic [wgm_pkg::RSP_DATA_W-1:0]   rsp_tdata   // [0] matched, [1] pattern_overflow
);

   import wgm_pkg::*;

   `include "wildcard_glob_matcher_top_assert.svh"

   // input register
   logic                 s1_valid_ff;
   action_type           s1_action_ff;
   logic [UNIT_W-1:0]    s1_unit_ff;

   // matcher state
   entry_type            store_ff [MAX_PATTERN];
   logic [LEN_W-1:0]     length_ff, length_in;
   logic                 ovf_ff, ovf_in;
   logic [NPOS-1:0]      active_ff, active_in;
   logic [NPOS-1:0]      lead_ff, lead_in;     // closure of the start state

   // result register
   logic                  rsp_valid_ff;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   logic                 s1_is_end;
   logic                 s1_fire;
   logic                 store_we;
   entry_type            app_entry;
   logic [MAX_PATTERN-1:0] in_len;
   logic [MAX_PATTERN-1:0] star_m;
   logic [NPOS-1:0]      step_set;
   logic                 hit;

   function automatic logic [NPOS-1:0] star_close(input logic [NPOS-1:0]        set,
                                                  input logic [MAX_PATTERN-1:0] star);
      logic [NPOS-1:0] g;
      logic [NPOS-1:0] p;
      int              d;
      g = set;
      p = {star, 1'b0};
      // prefix network: activity flows upward across runs of stars
      for (int lv = 0; lv < LVLS; lv++) begin
         d = 1 << lv;
         for (int j = NPOS - 1; j >= 0; j--) begin
            if (j >= d) begin
               g[j] = g[j] | (p[j] & g[j-d]);
               p[j] = p[j] & p[j-d];
            end
         end
      end
      return g;
   endfunction

   assign s1_is_end  = (s1_action_ff == ACT_END);
   assign s1_fire    = s1_valid_ff && (!s1_is_end || !rsp_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || s1_fire;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   always_comb begin
      for (int i = 0; i < MAX_PATTERN; i++) begin
         in_len[i] = (LEN_W'(i) < length_ff);
         star_m[i] = in_len[i] && (store_ff[i].kind == KIND_STAR);
      end
   end

   // one nfa step over all positions
   always_comb begin
      step_set = '0;
      for (int i = 0; i < MAX_PATTERN; i++) begin
         if (active_ff[i] && in_len[i]) begin
            if (store_ff[i].kind == KIND_STAR) begin
               step_set[i] = 1'b1;
            end else if (store_ff[i].kind == KIND_QUESTION ||
                         store_ff[i].unit == s1_unit_ff) begin
               step_set[i+1] = 1'b1;
            end
         end
      end
   end

   always_comb begin
      app_entry.unit = s1_unit_ff;
      if (s1_unit_ff == STAR_UNIT) begin
         app_entry.kind = KIND_STAR;
      end else if (s1_unit_ff == QUESTION_UNIT) begin
         app_entry.kind = KIND_QUESTION;
      end else begin
         app_entry.kind = KIND_LITERAL;
      end
   end

   assign hit = active_ff[length_ff];

   always_comb begin
      length_in   = length_ff;
      ovf_in      = ovf_ff;
      active_in   = active_ff;
      lead_in     = lead_ff;
      rsp_data_in = rsp_data_ff;
      store_we    = 1'b0;
      unique case (s1_action_ff)
         ACT_CLEAR: begin
            length_in = '0;
            ovf_in    = 1'b0;
            lead_in   = NPOS'(1);
            active_in = NPOS'(1);
         end
         ACT_APPEND: begin
            if (length_ff >= LEN_W'(MAX_PATTERN)) begin
               ovf_in    = 1'b1;
               active_in = lead_ff;
            end else begin
               store_we  = 1'b1;
               length_in = length_ff + LEN_W'(1);
               // start closure only grows while the pattern is all stars
               if (app_entry.kind == KIND_STAR && lead_ff[length_ff]) begin
                  lead_in = lead_ff | (NPOS'(2) << length_ff);
               end
               active_in = lead_in;
            end
         end
         ACT_TEXT: begin
            active_in = star_close(step_set, star_m);
         end
         ACT_END: begin
            active_in   = lead_ff;
            rsp_data_in = RSP_DATA_W'({ovf_ff, hit && !ovf_ff});
         end
         default: begin
            active_in = active_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         length_ff    <= '0;
         ovf_ff       <= 1'b0;
         active_ff    <= NPOS'(1);
         lead_ff      <= NPOS'(1);
      end else begin
         if (req_tready) begin
            s1_valid_ff <= req_tvalid;
         end
         if (s1_fire) begin
            length_ff <= length_in;
            ovf_ff    <= ovf_in;
            active_ff <= active_in;
            lead_ff   <= lead_in;
         end
         if (s1_fire && s1_is_end) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         s1_action_ff <= action_type'(req_tuser);
         s1_unit_ff   <= req_tdata[UNIT_W-1:0];
      end
      if (s1_fire && s1_is_end) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   // pattern store
   always_ff @(posedge clock) begin
      if (s1_fire && store_we) begin
         store_ff[length_ff[IDX_W-1:0]] <= app_entry;
      end
   end

   `WGM_ASSERT_IMPLY(a_len_bound, 1'b1, length_ff <= LEN_W'(MAX_PATTERN))
   `WGM_ASSERT_IMPLY(a_active_in_range, 1'b1, (active_ff >> (length_ff + LEN_W'(1))) == '0)
   `WGM_ASSERT_IMPLY(a_ovf_no_match, rsp_valid_ff && rsp_data_ff[1], !rsp_data_ff[0])
   `WGM_ASSERT_IMPLY(a_lead_start, 1'b1, lead_ff[0])
   `WGM_ASSERT_NEXT(a_end_held, s1_valid_ff && s1_is_end && rsp_valid_ff && !rsp_tready,
                    s1_valid_ff && s1_is_end)

endmodule

`default_nettype wire
